// File: rtl/gbi_pkg.sv
package gbi_pkg;

  localparam int WINDOW_LEN_DEF  = 5;
  localparam int CAL_SAMPLES_DEF = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ACC_W      = 48;
  localparam int DISCARD_W  = 10;
  localparam int THR_W      = 16;
  localparam int BAND_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DISCARD_MAX = (1 << DISCARD_W) - 1;

  localparam logic [DISCARD_W-1:0]    DISCARD_RST = DISCARD_W'(50);
  localparam logic signed [THR_W-1:0] FALL_THR_RST = -THR_W'(100);
  localparam logic [BAND_W-1:0]       STILL_BAND_RST = BAND_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_DISCARD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FALL_THR   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STILL_BAND = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    CMD_INTEGRATE = 2'd0,
    CMD_CAL       = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_RESTART   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic integ;
    logic cal;
    logic clear;
    logic restart;
  } step_ctl_t;

  typedef struct packed {
    logic [DISCARD_W-1:0]    discard_count;
    logic signed [THR_W-1:0] fall_threshold;
    logic [BAND_W-1:0]       still_band;
  } cfg_t;

endpackage

// File: rtl/gbi_if.sv
interface gbi_in_if #(
  parameter int SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic signed [SAMPLE_BITS-1:0] rate_y;
  logic signed [SAMPLE_BITS-1:0] rate_z;

  modport source (output valid, command, rate_y, rate_z, input ready);
  modport sink   (input valid, command, rate_y, rate_z, output ready);
endinterface

interface gbi_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gbi_pkg::ACC_W-1:0]  angle_y;
  logic signed [gbi_pkg::ACC_W-1:0]  angle_z;
  logic                              is_stopped;
  logic                              is_falling;
  logic                              bias_ready;

  modport source (output valid, angle_y, angle_z, is_stopped, is_falling, bias_ready,
                  input ready);
  modport sink   (input valid, angle_y, angle_z, is_stopped, is_falling, bias_ready,
                  output ready);
endinterface

// File: rtl/gyro_bias_integrate_motion_flags.sv
// Channel  Dir  Handshake     Payload
// in       in   valid/ready   command, rate_y, rate_z
// out      out  valid/ready   angle_y, angle_z, is_stopped, is_falling, bias_ready
// cfg      in   cfg_we        cfg_index, cfg_data
//
// One transaction per cycle sustained while out is ready; each goes through the
// input register, then a single-pass update into the state/result registers.
// The state registers are the result register: they update only as a transaction
// moves on, so a stalled result holds while the next transaction waits in the
// input register. rst is synchronous: state, windows, flags and config to defaults.
module gyro_bias_integrate_motion_flags #(
  parameter int WINDOW_LEN  = gbi_pkg::WINDOW_LEN_DEF,
  parameter int CAL_SAMPLES = gbi_pkg::CAL_SAMPLES_DEF,
  parameter int SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  gbi_in_if.sink                             in,
  gbi_out_if.source                          out,
  input  logic                               cfg_we,
  input  logic [gbi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(gbi_pkg::DISCARD_MAX + CAL_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  gbi_pkg::cfg_t                 cfg;
  logic                          in_valid_q;
  gbi_pkg::cmd_t                 cmd_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic signed [SAMPLE_BITS-1:0] z_q;
  logic                          out_valid;
  logic                          adv;
  gbi_pkg::step_ctl_t            ctl;
  logic signed [SUM_W-1:0]       bias_y;
  logic signed [SUM_W-1:0]       bias_z;

  assign adv      = in_valid_q && (!out_valid || out.ready);
  assign in.ready = !in_valid_q || adv;

  always_comb begin
    ctl = '0;
    if (adv) begin
      unique case (cmd_q)
        gbi_pkg::CMD_INTEGRATE: ctl.integ = 1'b1;
        gbi_pkg::CMD_CAL:       ctl.cal   = 1'b1;
        gbi_pkg::CMD_CLEAR:     ctl.clear = 1'b1;
        gbi_pkg::CMD_RESTART: begin
          ctl.clear   = 1'b1;
          ctl.restart = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.discard_count  <= gbi_pkg::DISCARD_RST;
      cfg.fall_threshold <= gbi_pkg::FALL_THR_RST;
      cfg.still_band     <= gbi_pkg::STILL_BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbi_pkg::REG_DISCARD:    cfg.discard_count  <= cfg_data[gbi_pkg::DISCARD_W-1:0];
        gbi_pkg::REG_FALL_THR:   cfg.fall_threshold <= $signed(cfg_data[gbi_pkg::THR_W-1:0]);
        gbi_pkg::REG_STILL_BAND: cfg.still_band     <= cfg_data[gbi_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in.valid && in.ready) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      cmd_q <= gbi_pkg::cmd_t'(in.command);
      y_q   <= in.rate_y;
      z_q   <= in.rate_z;
    end
  end

  gbi_cal #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_cal (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .discard_count (cfg.discard_count),
    .y             (y_q),
    .z             (z_q),
    .bias_y        (bias_y),
    .bias_z        (bias_z),
    .ready         (out.bias_ready)
  );

  gbi_acc #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_acc_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (y_q),
    .bias   (bias_y),
    .accum  (out.angle_y)
  );

  gbi_acc #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_acc_z (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (z_q),
    .bias   (bias_z),
    .accum  (out.angle_z)
  );

  gbi_window #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cfg        (cfg),
    .y          (y_q),
    .z          (z_q),
    .is_stopped (out.is_stopped),
    .is_falling (out.is_falling)
  );

  assign out.valid = out_valid;

  a_bias_ready_from_cal: assert property (@(posedge clk) disable iff (rst)
    $rose(out.bias_ready) |-> $past(ctl.cal))
    else $error("bias_ready rose without a calibration transaction");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (out.angle_y == '0) && (out.angle_z == '0))
    else $error("accumulators not zero after clear");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.integ |=> $stable(out.is_stopped) && $stable(out.is_falling))
    else $error("motion flags changed without an integrate transaction");

  a_state_only_on_adv: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(out.angle_y) && $stable(out.angle_z) && $stable(out.bias_ready))
    else $error("result changed while no transaction advanced");

endmodule

// File: rtl/gbi_cal.sv
module gbi_cal #(
  parameter int CAL_SAMPLES = gbi_pkg::CAL_SAMPLES_DEF,
  parameter int SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 27
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gbi_pkg::step_ctl_t                  ctl,
  input  logic [gbi_pkg::DISCARD_W-1:0]       discard_count,
  input  logic signed [SAMPLE_BITS-1:0]       y,
  input  logic signed [SAMPLE_BITS-1:0]       z,
  output logic signed [SUM_W-1:0]             bias_y,
  output logic signed [SUM_W-1:0]             bias_z,
  output logic                                ready
);

  localparam int CNT_W = $clog2(gbi_pkg::DISCARD_MAX + CAL_SAMPLES + 1);

  logic [CNT_W-1:0]        cal_count;
  logic [CNT_W-1:0]        cal_count_next;
  logic [CNT_W-1:0]        end_count;
  logic signed [SUM_W-1:0] cal_sum_y;
  logic signed [SUM_W-1:0] cal_sum_z;
  logic signed [SUM_W-1:0] cal_sum_y_next;
  logic signed [SUM_W-1:0] cal_sum_z_next;
  logic                    summing;

  assign cal_count_next = cal_count + CNT_W'(1);
  assign end_count      = CNT_W'(discard_count) + CNT_W'(CAL_SAMPLES);
  assign summing        = cal_count >= CNT_W'(discard_count);
  assign cal_sum_y_next = cal_sum_y + SUM_W'(y);
  assign cal_sum_z_next = cal_sum_z + SUM_W'(z);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count <= '0;
      cal_sum_y <= '0;
      cal_sum_z <= '0;
      bias_y    <= '0;
      bias_z    <= '0;
      ready     <= 1'b0;
    end else if (ctl.restart) begin
      cal_count <= '0;
      cal_sum_y <= '0;
      cal_sum_z <= '0;
      ready     <= 1'b0;
    end else if (ctl.cal && !ready) begin
      cal_count <= cal_count_next;
      if (summing) begin
        cal_sum_y <= cal_sum_y_next;
        cal_sum_z <= cal_sum_z_next;
        if (cal_count_next >= end_count) begin
          bias_y <= cal_sum_y_next;
          bias_z <= cal_sum_z_next;
          ready  <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/gbi_acc.sv
module gbi_acc #(
  parameter int CAL_SAMPLES = gbi_pkg::CAL_SAMPLES_DEF,
  parameter int SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 27
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gbi_pkg::step_ctl_t                 ctl,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic signed [SUM_W-1:0]            bias,
  output logic signed [gbi_pkg::ACC_W-1:0]   accum
);

  localparam int ACC_W = gbi_pkg::ACC_W;
  localparam int EXT_W = ACC_W + 2;

  localparam logic signed [EXT_W-1:0] CAL_S   = EXT_W'(CAL_SAMPLES);
  localparam logic signed [EXT_W-1:0] ACC_MAX = EXT_W'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] ACC_MIN = -ACC_MAX - EXT_W'(1);

  logic signed [EXT_W-1:0] scaled;
  logic signed [EXT_W-1:0] total;
  logic signed [ACC_W-1:0] accum_next;

  assign scaled = EXT_W'(sample) * CAL_S;
  assign total  = EXT_W'(accum) + scaled - EXT_W'(bias);

  always_comb begin
    priority if (total > ACC_MAX) begin
      accum_next = ACC_MAX[ACC_W-1:0];
    end else if (total < ACC_MIN) begin
      accum_next = ACC_MIN[ACC_W-1:0];
    end else begin
      accum_next = total[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
    end else if (ctl.clear) begin
      accum <= '0;
    end else if (ctl.integ) begin
      accum <= accum_next;
    end
  end

endmodule

// File: rtl/gbi_window.sv
module gbi_window #(
  parameter int WINDOW_LEN  = gbi_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gbi_pkg::step_ctl_t            ctl,
  input  gbi_pkg::cfg_t                 cfg,
  input  logic signed [SAMPLE_BITS-1:0] y,
  input  logic signed [SAMPLE_BITS-1:0] z,
  output logic                          is_stopped,
  output logic                          is_falling
);

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CMP_W  = ((SAMPLE_BITS > gbi_pkg::THR_W) ? SAMPLE_BITS : gbi_pkg::THR_W) + 1;

  logic signed [SAMPLE_BITS-1:0] win_y [WINDOW_LEN];
  logic signed [SAMPLE_BITS-1:0] win_z [WINDOW_LEN];
  logic [SLOT_W-1:0]             slot;
  logic                          stopped_next;
  logic                          falling_next;
  logic signed [CMP_W-1:0]       band_hi;
  logic signed [CMP_W-1:0]       band_lo;
  logic signed [CMP_W-1:0]       thr;

  assign band_hi = $signed({{(CMP_W-gbi_pkg::BAND_W){1'b0}}, cfg.still_band});
  assign band_lo = -band_hi;
  assign thr     = CMP_W'(cfg.fall_threshold);

  // flags see the window with this transaction's samples already in place
  always_comb begin
    logic signed [CMP_W-1:0] wy;
    logic signed [CMP_W-1:0] wz;
    stopped_next = 1'b1;
    falling_next = 1'b1;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      wy = (slot == SLOT_W'(i)) ? CMP_W'(y) : CMP_W'(win_y[i]);
      wz = (slot == SLOT_W'(i)) ? CMP_W'(z) : CMP_W'(win_z[i]);
      if (wz > band_hi || wz < band_lo) stopped_next = 1'b0;
      if (wy > thr) falling_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_y[i] <= '0;
        win_z[i] <= '0;
      end
      slot       <= '0;
      is_stopped <= 1'b0;
      is_falling <= 1'b0;
    end else if (ctl.integ) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        if (slot == SLOT_W'(i)) begin
          win_y[i] <= y;
          win_z[i] <= z;
        end
      end
      slot       <= (slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot + SLOT_W'(1);
      is_stopped <= stopped_next;
      is_falling <= falling_next;
    end
  end

endmodule

// File: sim/gyro_bias_integrate_motion_flags_test.sv
module gyro_bias_integrate_motion_flags_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gbi_pkg::*;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     ITEM_TARGET = 1700;
  localparam int     CAL_BUDGET  = 900;
  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef struct {
    logic signed [ACC_W-1:0] angle_y;
    logic signed [ACC_W-1:0] angle_z;
    logic                    is_stopped;
    logic                    is_falling;
    logic                    bias_ready;
  } motion_result_t;

  class motion_tracker;
    int             discard_len;
    int             fall_thr;
    int             band;
    longint         acc_y, acc_z;
    longint         bias_y, bias_z;
    longint         sum_y, sum_z;
    int             cal_seen;
    int             win_y[WINDOW_LEN_DEF];
    int             win_z[WINDOW_LEN_DEF];
    int             slot;
    bit             stopped, falling, bias_loaded;
    motion_result_t due_results[$];
    int             errors;

    function new();
      discard_len = DISCARD_RST;
      fall_thr    = int'(FALL_THR_RST);
      band        = STILL_BAND_RST;
      acc_y = 0; acc_z = 0;
      bias_y = 0; bias_z = 0;
      sum_y = 0; sum_z = 0;
      cal_seen = 0;
      foreach (win_y[i]) begin
        win_y[i] = 0;
        win_z[i] = 0;
      end
      slot = 0;
      stopped = 0; falling = 0; bias_loaded = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DISCARD:    discard_len = data[DISCARD_W-1:0];
        REG_FALL_THR:   fall_thr = int'($signed(data[THR_W-1:0]));
        REG_STILL_BAND: band = data[BAND_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip48(longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void absorb_sample(cmd_t cmd, logic signed [15:0] y, logic signed [15:0] z);
      motion_result_t r;
      case (cmd)
        CMD_INTEGRATE: begin
          acc_y = clip48(acc_y + longint'(y) * CAL_SAMPLES_DEF - bias_y);
          acc_z = clip48(acc_z + longint'(z) * CAL_SAMPLES_DEF - bias_z);
          win_y[slot] = y;
          win_z[slot] = z;
          slot = (slot + 1) % WINDOW_LEN_DEF;
          stopped = 1'b1;
          falling = 1'b1;
          for (int i = 0; i < WINDOW_LEN_DEF; i++) begin
            if (win_z[i] > band || win_z[i] < -band) stopped = 1'b0;
            if (win_y[i] > fall_thr) falling = 1'b0;
          end
        end
        CMD_CAL: begin
          if (!bias_loaded) begin
            if (cal_seen < discard_len) begin
              cal_seen++;
            end else begin
              sum_y += y;
              sum_z += z;
              cal_seen++;
              if (cal_seen >= discard_len + CAL_SAMPLES_DEF) begin
                bias_y = sum_y;
                bias_z = sum_z;
                bias_loaded = 1'b1;
              end
            end
          end
        end
        default: begin
          acc_y = 0;
          acc_z = 0;
          if (cmd == CMD_RESTART) begin
            sum_y = 0;
            sum_z = 0;
            cal_seen = 0;
            bias_loaded = 1'b0;
          end
        end
      endcase
      r.angle_y    = acc_y[ACC_W-1:0];
      r.angle_z    = acc_z[ACC_W-1:0];
      r.is_stopped = stopped;
      r.is_falling = falling;
      r.bias_ready = bias_loaded;
      due_results.push_back(r);
    endfunction

    function void match(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic signed [ACC_W-1:0] ay, logic signed [ACC_W-1:0] az,
                               logic st, logic fa, logic br);
      motion_result_t w;
      if (due_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
        return;
      end
      w = due_results.pop_front();
      match("angle_y", w.angle_y, ay);
      match("angle_z", w.angle_z, az);
      match("is_stopped", w.is_stopped, st);
      match("is_falling", w.is_falling, fa);
      match("bias_ready", w.bias_ready, br);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gbi_in_if  in_if ();
  gbi_out_if out_if ();

  gyro_bias_integrate_motion_flags dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_if.sink),
    .out       (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  motion_tracker tracker;
  int            cycle_count = 0;
  int            items_sent = 0;
  bit            no_idle = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] to_rate(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  task automatic pick_rates(bit quiet, output logic signed [15:0] y, output logic signed [15:0] z);
    if (quiet) begin
      y = to_rate(-32768 + int'($urandom_range(tracker.fall_thr + 32768)));
      z = to_rate(-tracker.band + int'($urandom_range(2 * tracker.band)));
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          y = 16'($urandom);
          z = 16'($urandom);
        end
        4, 5: begin
          y = pick_extreme();
          z = pick_extreme();
        end
        default: begin
          y = to_rate(tracker.fall_thr + int'($urandom_range(4)) - 2);
          z = to_rate(($urandom_range(1) ? tracker.band : -tracker.band)
                      + int'($urandom_range(4)) - 2);
        end
      endcase
    end
  endtask

  task automatic send_item(cmd_t cmd, logic signed [15:0] y, logic signed [15:0] z);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.rate_y  <= y;
    in_if.rate_z  <= z;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    tracker.absorb_sample(cmd, y, z);
    @(negedge clk);
  endtask

  // drain every outstanding transaction, then give the pipeline time to empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(int discard, int thr, int band);
    write_one(REG_DISCARD, {6'($urandom), 10'(discard)});
    write_one(REG_FALL_THR, 16'(thr));
    write_one(REG_STILL_BAND, {1'($urandom), 15'(band)});
    write_one(REG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic integrate_run(int n);
    int                 left;
    int                 r;
    bit                 quiet;
    logic signed [15:0] y, z;
    left  = 0;
    quiet = 1'b0;
    repeat (n) begin
      if (left == 0) begin
        quiet = ~quiet;
        left  = $urandom_range(3, 12);
      end
      left--;
      pick_rates(quiet, y, z);
      r = $urandom_range(99);
      if (r < 4) send_item(CMD_CLEAR, y, z);
      else if (r < 7) send_item(CMD_CAL, y, z);
      else if (r < 8) send_item(CMD_RESTART, y, z);
      else send_item(CMD_INTEGRATE, y, z);
    end
  endtask

  task automatic calibrate_to_ready();
    int                 mode;
    int                 r;
    logic signed [15:0] y, z;
    mode = $urandom_range(2);
    while (!tracker.bias_loaded) begin
      case (mode)
        0: begin
          y = 16'($urandom);
          z = 16'($urandom);
        end
        1: begin
          y = 16'sh7fff;
          z = 16'sh8000;
        end
        default: begin
          y = 16'sh8000;
          z = 16'sh7fff;
        end
      endcase
      r = $urandom_range(99);
      if (r < 88) begin
        send_item(CMD_CAL, y, z);
      end else if (r < 97) begin
        pick_rates(r[0], y, z);
        send_item(CMD_INTEGRATE, y, z);
      end else begin
        send_item(CMD_CLEAR, y, z);
      end
    end
  endtask

  task automatic directed();
    send_item(CMD_INTEGRATE, 16'sh7fff, 16'sh8000);
    send_item(CMD_INTEGRATE, 16'sh8000, 16'sh7fff);
    send_item(CMD_INTEGRATE, 16'sh0000, 16'sh0000);
    send_item(CMD_CLEAR, 16'sh1234, -16'sh0321);
    // fill the window right at the default thresholds
    send_item(CMD_INTEGRATE, -16'sd100, 16'sd100);
    send_item(CMD_INTEGRATE, -16'sd101, -16'sd100);
    send_item(CMD_INTEGRATE, 16'sh8000, 16'sh0000);
    send_item(CMD_INTEGRATE, -16'sd100, -16'sd100);
    send_item(CMD_INTEGRATE, -16'sd200, 16'sd50);
    send_item(CMD_CLEAR, 16'sh7fff, 16'sh7fff);
    send_item(CMD_INTEGRATE, -16'sd99, 16'sd101);
    send_item(CMD_CAL, 16'sh7fff, 16'sh7fff);
    send_item(CMD_CAL, 16'sh8000, 16'sh8000);
    send_item(CMD_RESTART, 16'sh5555, 16'shaaaa);
    send_item(CMD_INTEGRATE, -16'sd1, -16'sd1);
    send_item(CMD_RESTART, 16'shffff, 16'shffff);
    send_item(CMD_INTEGRATE, 16'sd1, 16'sd1);
  endtask

  task automatic run_random();
    int                 phase;
    int                 run_len;
    logic signed [15:0] y, z;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      no_idle = (phase % 4 == 3);
      case (phase)
        0: configure(DISCARD_MAX, 32767, 0);
        1: configure(0, -32768, 32767);
        default: configure(($urandom_range(5) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(0, 10),
                           $urandom_range(1) ? int'($urandom_range(400)) - 200
                                             : int'($urandom_range(65535)) - 32768,
                           $urandom_range(1) ? $urandom_range(300)
                                             : $urandom_range(32767));
      endcase
      if (phase == 0) begin
        // calibration left part-way, so the next phase lowers the discard length mid-way
        send_item(CMD_RESTART, 16'($urandom), 16'($urandom));
        repeat (40) begin
          send_item(CMD_CAL, 16'($urandom), 16'($urandom));
          pick_rates(1'($urandom_range(1)), y, z);
          send_item(CMD_INTEGRATE, y, z);
        end
      end else if (phase == 1) begin
        calibrate_to_ready();
      end else if (ITEM_TARGET - items_sent > CAL_BUDGET && $urandom_range(1)) begin
        send_item(CMD_RESTART, 16'($urandom), 16'($urandom));
        calibrate_to_ready();
      end
      run_len = $urandom_range(80, 200);
      if (run_len > ITEM_TARGET - items_sent) run_len = ITEM_TARGET - items_sent;
      if (run_len > 0) integrate_run(run_len);
      phase++;
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.command = CMD_INTEGRATE;
    in_if.rate_y  = '0;
    in_if.rate_z  = '0;
    tracker = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed();
    run_random();
    settle();
    repeat (6) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (!rst && out_if.valid && out_if.ready) begin
      tracker.check_result(out_if.angle_y, out_if.angle_z, out_if.is_stopped,
                           out_if.is_falling, out_if.bias_ready);
    end
  end

endmodule
